>>> src/rsnh_pkg.sv
// ----------------------------------------------------------------------------
// rsnh_pkg
// Types and constants shared by the ray/sphere nearest-hit block.
// ----------------------------------------------------------------------------
package rsnh_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAST = 1'b1;

  localparam logic [1:0] CFG_ACTIVE = 2'd0;
  localparam logic [1:0] CFG_NEAR   = 2'd1;
  localparam logic [1:0] CFG_FAR    = 2'd2;

  localparam int SQRT_BITS = 41;

  typedef struct packed {
    logic               operation;
    logic [3:0]         slot;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [30:0]        radius;
    logic [23:0]        colour;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  hit_slot;
    logic [30:0] distance;
    logic [23:0] hit_colour;
  } out_item_t;

endpackage

>>> src/rsnh_sqrt.sv
// ----------------------------------------------------------------------------
// rsnh_sqrt
// Bit-serial floor square root of an 82-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module rsnh_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [81:0] radicand,
  output logic        done,
  output logic [40:0] root
);
  import rsnh_pkg::*;

  logic [81:0] rem;
  logic [40:0] res;
  logic [5:0]  bit_idx;
  logic        running;
  logic [83:0] trial;

  // classic restoring digit recurrence: trial = (res*2 + (1 << bit)) << bit
  always_comb begin
    trial = ({43'd0, res} << (bit_idx + 6'd1)) | (84'd1 << (2 * bit_idx));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        bit_idx <= 6'(SQRT_BITS - 1);
        rem     <= radicand;
        res     <= '0;
      end else if (running) begin
        if ({2'b00, rem} >= trial) begin
          rem <= rem - trial[81:0];
          res <= res | (41'd1 << bit_idx);
        end
        if (bit_idx == 6'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          bit_idx <= bit_idx - 6'd1;
        end
      end
    end
  end

  assign root = res;

endmodule

>>> src/ray_sphere_nearest_hit.sv
// ----------------------------------------------------------------------------
// ray_sphere_nearest_hit
// Sphere table in on-chip memory with a nearest-hit ray caster.
// ----------------------------------------------------------------------------
// A load item writes one sphere slot. A cast item walks slots
// 0 .. min(active_spheres, MAX_SPHERES)-1 one at a time. Each slot takes a
// memory read, arithmetic steps (vector, multiply, dot, square, discriminant),
// a bit-serial square root and a pick step. A slot with a negative
// discriminant skips the root. busy is high for the whole cast. The
// result appears with done for one cycle as busy falls, and the receiver
// cannot stall it. Loads and casts never overlap, so the table needs no
// forwarding.
module ray_sphere_nearest_hit #(
  parameter int MAX_SPHERES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rsnh_pkg::in_item_t  in_item,
  output logic                done,
  output rsnh_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);
  import rsnh_pkg::*;

  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW = $clog2(MAX_SPHERES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_VEC  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DOT  = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_DISC = 4'd6;
  localparam logic [3:0] S_ROOT = 4'd7;
  localparam logic [3:0] S_PICK = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        r;
    logic [23:0]        col;
  } sphere_t;

  sphere_t mem [MAX_SPHERES];
  sphere_t rd;

  logic [4:0]  active_spheres;
  logic [15:0] dist_min;
  logic [30:0] dist_max;

  logic [3:0]  state;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic signed [31:0] ox, oy, oz;
  logic signed [15:0] dx, dy, dz;

  logic signed [32:0] vx, vy, vz;
  logic signed [48:0] mx, my, mz;
  logic signed [50:0] dot;
  logic signed [35:0] front;
  logic [65:0]        sx, sy, sz, sr;
  logic [67:0]        sf;
  logic [81:0]        disc;
  logic               neg;
  logic               sq_start, sq_done;
  logic [40:0]        back;

  logic [30:0]   best;
  logic          found;
  logic [AW-1:0] best_slot;
  logic [23:0]   best_col;

  logic signed [51:0] nd;
  logic signed [51:0] t_hi, t_lo, t_sel;
  logic [67:0]        p_sum, q_sum;
  logic               accept;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_spheres <= 5'd0;
      dist_min       <= 16'd66;
      dist_max       <= 31'h7FFF_FFFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE: active_spheres <= cfg_data[4:0];
        CFG_NEAR:   dist_min       <= cfg_data[15:0];
        CFG_FAR:    dist_max       <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy && in_item.operation == OP_LOAD &&
        32'(in_item.slot) < 32'(MAX_SPHERES)) begin
      mem[AW'(in_item.slot)] <= '{in_item.px, in_item.py, in_item.pz,
                                  in_item.radius, in_item.colour};
    end
    rd <= mem[idx[AW-1:0]];
  end

  rsnh_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (disc),
    .done     (sq_done),
    .root     (back)
  );

  always_comb begin
    nd    = -52'(dot);
    p_sum = sf + {2'b00, sr};
    q_sum = {2'b00, sx} + {2'b00, sy} + {2'b00, sz};
    neg   = (p_sum < q_sum);
    disc  = 82'(p_sum - q_sum);
    t_hi  = 52'(front) + 52'(signed'({1'b0, back}));
    t_lo  = 52'(front) - 52'(signed'({1'b0, back}));
    t_sel = (t_lo <= 52'(signed'({1'b0, dist_min}))) ? t_hi : t_lo;
    accept = !neg && (t_hi > 52'(signed'({1'b0, dist_min}))) &&
             (t_sel < 52'(signed'({1'b0, best})));
  end

  assign sq_start = (state == S_ROOT) && !neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && in_item.operation == OP_CAST) begin
            ox <= in_item.px; oy <= in_item.py; oz <= in_item.pz;
            dx <= in_item.dir_x; dy <= in_item.dir_y; dz <= in_item.dir_z;
            idx   <= '0;
            count <= (32'(active_spheres) > 32'(MAX_SPHERES)) ? CW'(MAX_SPHERES)
                                                               : CW'(active_spheres);
            best  <= dist_max;
            found <= 1'b0;
            best_slot <= '0;
            best_col  <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= (idx == count) ? S_OUT : S_VEC;
        end
        S_VEC: begin
          vx <= 33'(ox) - 33'(rd.cx);
          vy <= 33'(oy) - 33'(rd.cy);
          vz <= 33'(oz) - 33'(rd.cz);
          state <= S_MUL;
        end
        S_MUL: begin
          mx <= 49'(vx) * 49'(dx);
          my <= 49'(vy) * 49'(dy);
          mz <= 49'(vz) * 49'(dz);
          sx <= 66'(vx < 0 ? -vx : vx) * 66'(vx < 0 ? -vx : vx);
          sy <= 66'(vy < 0 ? -vy : vy) * 66'(vy < 0 ? -vy : vy);
          state <= S_DOT;
        end
        S_DOT: begin
          dot <= 51'(mx) + 51'(my) + 51'(mz);
          sz  <= 66'(vz < 0 ? -vz : vz) * 66'(vz < 0 ? -vz : vz);
          sr  <= 66'(rd.r) * 66'(rd.r);
          state <= S_SQ;
        end
        S_SQ: begin
          // floor division by 2^15
          front <= 36'(nd >>> 15);
          state <= S_DISC;
        end
        S_DISC: begin
          sf <= 68'(front < 0 ? -front : front) * 68'(front < 0 ? -front : front);
          state <= S_ROOT;
        end
        S_ROOT: begin
          // root starts here unless the discriminant is negative
          state <= S_PICK;
        end
        S_PICK: begin
          if (neg || sq_done) begin
            if (accept) begin
              best      <= 31'(t_sel);
              found     <= 1'b1;
              best_slot <= idx[AW-1:0];
              best_col  <= rd.col;
            end
            idx   <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_item.hit        = found;
  assign out_item.hit_slot   = found ? 4'(best_slot) : 4'd0;
  assign out_item.distance   = best;
  assign out_item.hit_colour = found ? best_col : 24'd0;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray/sphere nearest-hit block: directed and
// random loads and casts under changing clip settings, with every cast result
// checked against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
  import rsnh_pkg::*;

  class hit_scoreboard;
    longint          ctr_x [16];
    longint          ctr_y [16];
    longint          ctr_z [16];
    longint unsigned rad   [16];
    logic [23:0]     col   [16];
    int unsigned     n_active = 0;
    longint          near_lim = 66;
    longint          far_lim  = 64'h7FFF_FFFF;
    out_item_t       pending[$];
    int              errors = 0;

    function void set_reg(logic [1:0] idx, logic [30:0] val);
      case (idx)
        CFG_ACTIVE: n_active = val[4:0];
        CFG_NEAR:   near_lim = val[15:0];
        CFG_FAR:    far_lim  = val;
        default: ;
      endcase
    endfunction

    function longint unsigned isqrt(logic [127:0] d);
      longint unsigned r, c;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= d) r = c;
      end
      return r;
    endfunction

    // distance to slot s, or -1 on a miss
    function longint sphere_dist(int s, longint ox, longint oy, longint oz,
                                 longint dx, longint dy, longint dz);
      longint vx, vy, vz, dot, front, back, mx, mn;
      logic signed [127:0] f, r, p, q;
      vx = ox - ctr_x[s];
      vy = oy - ctr_y[s];
      vz = oz - ctr_z[s];
      dot = vx * dx + vy * dy + vz * dz;
      front = (-dot) >>> 15;
      f = front;
      r = $signed({1'b0, rad[s]});
      p = f * f + r * r;
      q = 128'(vx) * 128'(vx) + 128'(vy) * 128'(vy) + 128'(vz) * 128'(vz);
      if (p < q) return -1;
      back = isqrt(p - q);
      mx = front + back;
      mn = front - back;
      if (mx <= near_lim) return -1;
      return (mn <= near_lim) ? mx : mn;
    endfunction

    function void note_item(in_item_t it);
      out_item_t e;
      longint best, t;
      int n;
      if (it.operation == OP_LOAD) begin
        ctr_x[it.slot] = it.px;
        ctr_y[it.slot] = it.py;
        ctr_z[it.slot] = it.pz;
        rad[it.slot]   = it.radius;
        col[it.slot]   = it.colour;
        return;
      end
      n = (n_active > 16) ? 16 : n_active;
      best = far_lim;
      e = '0;
      for (int i = 0; i < n; i++) begin
        t = sphere_dist(i, it.px, it.py, it.pz, it.dir_x, it.dir_y, it.dir_z);
        if (t >= 0 && t < best && t > near_lim) begin
          best = t;
          e.hit = 1'b1;
          e.hit_slot = 4'(i);
          e.hit_colour = col[i];
        end
      end
      e.distance = best[30:0];
      pending.push_back(e);
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, a.hit); errors++;
      end
      if (a.hit_slot !== e.hit_slot) begin
        $error("hit_slot exp %0d got %0d", e.hit_slot, a.hit_slot); errors++;
      end
      if (a.distance !== e.distance) begin
        $error("distance exp %0d got %0d", e.distance, a.distance); errors++;
      end
      if (a.hit_colour !== e.hit_colour) begin
        $error("hit_colour exp %h got %h", e.hit_colour, a.hit_colour); errors++;
      end
    endfunction
  endclass

  localparam longint CYCLE_LIMIT = 8_000_000;
  localparam int ONE = 65536;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        done;
  out_item_t   out_item;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  hit_scoreboard hits = new();
  longint cycles = 0;
  int idle_pct = 0;

  ray_sphere_nearest_hit dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) if (!rst && done) hits.check_result(out_item);

  task automatic send(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 0;
    end
    @(negedge clk);
    start = 1;
    in_item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    hits.note_item(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    hits.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    while (hits.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic in_item_t load_item(int s, longint x, longint y, longint z,
                                         longint r, int c);
    in_item_t it;
    it = '0;
    it.operation = OP_LOAD;
    it.slot = 4'(s);
    it.px = 32'(x); it.py = 32'(y); it.pz = 32'(z);
    it.radius = 31'(r);
    it.colour = 24'(c);
    return it;
  endfunction

  function automatic in_item_t cast_item(longint x, longint y, longint z,
                                         int dx, int dy, int dz);
    in_item_t it;
    it = '0;
    it.operation = OP_CAST;
    it.px = 32'(x); it.py = 32'(y); it.pz = 32'(z);
    it.dir_x = 16'(dx); it.dir_y = 16'(dy); it.dir_z = 16'(dz);
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic longint coord(int span);
    return longint'($urandom_range(2 * span * ONE)) - longint'(span) * ONE;
  endfunction

  // unit ray from a random origin toward one table slot, lightly jittered
  function automatic in_item_t aimed_cast(int s);
    longint ox, oy, oz;
    real ddx, ddy, ddz, len;
    ox = coord(40); oy = coord(40); oz = coord(40);
    ddx = real'(hits.ctr_x[s] - ox) + real'(coord(2));
    ddy = real'(hits.ctr_y[s] - oy) + real'(coord(2));
    ddz = real'(hits.ctr_z[s] - oz) + real'(coord(2));
    len = $sqrt(ddx * ddx + ddy * ddy + ddz * ddz);
    if (len < 1.0) return cast_item(ox, oy, oz, 0, 0, 32767);
    return cast_item(ox, oy, oz, int'(ddx / len * 32767.0),
                     int'(ddy / len * 32767.0), int'(ddz / len * 32767.0));
  endfunction

  initial begin
    int unsigned act_set[8] = '{16, 1, 31, 0, 8, 17, 16, 5};
    int n_act;
    in_item_t it;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_reg(CFG_ACTIVE, 31'd16);
    write_reg(CFG_NEAR, 31'd66);
    write_reg(CFG_FAR, 31'h7FFF_FFFF);

    // directed: fill the table, then corner-case rays
    for (int s = 0; s < 13; s++)
      send(load_item(s, longint'(s) * 3 * ONE, 0, 10 * ONE, ONE, s * 111111));
    send(load_item(13, 0, 0, 20 * ONE, 2 * ONE, 24'hABCDEF));
    send(load_item(14, 0, 0, 20 * ONE, 2 * ONE, 24'h123456));   // tie with 13
    send(load_item(15, -64'sh8000_0000, 64'sh7FFF_FFFF, 0, 31'h7FFF_FFFF,
                   24'hFFFFFF));
    send(cast_item(0, 0, 0, 0, 0, 32767));                // front hit
    send(cast_item(0, 0, 10 * ONE, 0, 0, 32767));         // origin inside
    send(cast_item(0, 0, 30 * ONE, 0, 0, 32767));         // spheres behind
    send(cast_item(0, 0, 30 * ONE, 0, 0, -32768));        // looking back
    send(cast_item(0, 0, 0, 32767, 32767, 32767));        // not normalised
    send(cast_item(0, 0, 0, 0, 0, 0));                    // zero direction
    send(cast_item(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                   -32768, -32768, -32768));
    send(cast_item(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                   32767, -32768, 32767));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ACTIVE, act_set[ph] == 5 ? 31'($urandom_range(31))
                                             : 31'(act_set[ph]));
      case (ph % 4)
        0: write_reg(CFG_NEAR, 31'd0);
        1: write_reg(CFG_NEAR, 31'h0000_FFFF);
        2: write_reg(CFG_NEAR, 31'd66);
        default: write_reg(CFG_NEAR, 31'($urandom_range(16'hFFFF)));
      endcase
      case (ph)
        3: write_reg(CFG_FAR, 31'd0);
        5: write_reg(CFG_FAR, 31'(30 * ONE));
        6: write_reg(CFG_FAR, 31'($urandom_range(31'h7FFF_FFFF)));
        default: write_reg(CFG_FAR, 31'h7FFF_FFFF);
      endcase
      n_act = (hits.n_active > 16) ? 16 : hits.n_active;
      case (ph % 4)
        1: idle_pct = 71;
        3: idle_pct = 18;
        default: idle_pct = 0;
      endcase
      for (int k = 0; k < 195; k++) begin
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
          it = load_item($urandom_range(15), coord(20), coord(20), coord(20),
                         $urandom_range(5 * ONE, ONE / 2), $urandom);
        else if (pick < 80 && n_act > 0)
          it = aimed_cast($urandom_range(n_act - 1));
        else
          it = noise_item();
        send(it);
      end
      drain();
    end

    idle_pct = 0;
    repeat (1000) @(posedge clk);
    if (hits.errors == 0 && hits.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
